[hw/rtl/mer_pkg.sv]
// Shared constants and types of the midpoint ellipse rasteriser.
`timescale 1ns / 1ps

package mer_pkg;

    localparam int MAX_RADIUS = 1023;

    localparam int RAD_W   = 10;
    localparam int RSQ_W   = 20;
    localparam int X_W     = 12;
    localparam int Y_W     = 11;
    localparam int DEC_W   = 48;
    localparam int DSTEP_W = 36;
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = 48;

    localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);

    // point handed to the emitter; it expands into the mirror copies
    typedef struct packed {
        logic                  valid;
        logic signed [X_W-1:0] x;
        logic signed [Y_W-1:0] y;
        logic                  last;
    } t_emit_req;

endpackage

[hw/rtl/mer_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module mer_mul (
    input  logic                                 i_clk,
    input  logic signed [mer_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [mer_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [mer_pkg::PROD_W-1:0]    o_prod
);

    logic signed [mer_pkg::MUL_A_W+mer_pkg::MUL_B_W-1:0] full_prod;
    logic signed [mer_pkg::PROD_W-1:0]                   r_prod;

    assign full_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= full_prod[mer_pkg::PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/mer_emit.sv]
// Mirror-copy emitter: one quadrant copy per cycle into the output register, bar stalls.
`timescale 1ns / 1ps

module mer_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mer_pkg::t_emit_req                 i_req,
    output logic                               o_busy,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [mer_pkg::X_W-1:0]     o_x_pos,
    output logic signed [mer_pkg::Y_W-1:0]     o_y_pos,
    output logic                               o_last
);

    logic                              r_busy, n_busy;
    logic [1:0]                        r_idx, n_idx;
    logic [3:0]                        r_mask, n_mask;
    logic signed [mer_pkg::X_W-1:0]    r_src_x, n_src_x;
    logic signed [mer_pkg::Y_W-1:0]    r_src_y, n_src_y;
    logic                              r_src_last, n_src_last;

    logic                              r_ov, n_ov;
    logic signed [mer_pkg::X_W-1:0]    r_ox, n_ox;
    logic signed [mer_pkg::Y_W-1:0]    r_oy, n_oy;
    logic                              r_ol, n_ol;

    logic                              load;
    logic [3:0]                        above;
    logic                              has_next;
    logic [1:0]                        next_idx;

    // copies still enabled after the current one
    assign above    = r_mask & (4'b1110 << r_idx);
    assign has_next = |above;
    assign load     = r_busy && (!r_ov || i_ready);

    always_comb begin
        next_idx = r_idx;
        for (int k = 3; k >= 0; k--) begin
            if (above[k]) begin
                next_idx = 2'(k);
            end
        end
    end

    always_comb begin
        n_busy     = r_busy;
        n_idx      = r_idx;
        n_mask     = r_mask;
        n_src_x    = r_src_x;
        n_src_y    = r_src_y;
        n_src_last = r_src_last;
        n_ov       = r_ov && !i_ready;
        n_ox       = r_ox;
        n_oy       = r_oy;
        n_ol       = r_ol;

        if (load) begin
            n_ov  = 1'b1;
            n_ox  = r_idx[0] ? -r_src_x : r_src_x;
            n_oy  = r_idx[1] ? -r_src_y : r_src_y;
            n_ol  = r_src_last && !has_next;
            n_idx = next_idx;
            if (!has_next) begin
                n_busy = 1'b0;
            end
        end

        if (i_req.valid) begin
            n_busy     = 1'b1;
            n_idx      = 2'd0;
            n_src_x    = i_req.x;
            n_src_y    = i_req.y;
            n_src_last = i_req.last;
            n_mask     = {(i_req.x != '0) && (i_req.y != '0), i_req.y != '0,
                          i_req.x != '0, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask     <= n_mask;
        r_src_x    <= n_src_x;
        r_src_y    <= n_src_y;
        r_src_last <= n_src_last;
        r_ox       <= n_ox;
        r_oy       <= n_oy;
        r_ol       <= n_ol;
    end

    assign o_busy  = r_busy;
    assign o_valid = r_ov;
    assign o_x_pos = r_ox;
    assign o_y_pos = r_oy;
    assign o_last  = r_ol;

endmodule

[hw/rtl/midpoint_ellipse_rasterizer.sv]
// Top level: sequencer and datapath of the 2:1 midpoint ellipse rasteriser.
`timescale 1ns / 1ps

// Draws an ellipse with vertical radius r and horizontal radius 2r. A start
// request (mode 0) loads r and produces no points; it forms r^2 and then r^3
// in the one shared multiplier. Each step request (mode 1) yields one point
// of the first quadrant plus its mirror copies, copies with a negated zero
// coordinate left out, so 1 to 4 points leave per step; a step ends once the
// emitter has put every copy into the output register, one per cycle while
// the output is not stalled, and the step where region 2 begins first passes
// three products through the shared multiplier. o_last marks the final point
// of the ellipse; a step after that gives nothing until the next start. The
// block takes one request at a time.
module midpoint_ellipse_rasterizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_mode,
    input  logic [mer_pkg::RAD_W-1:0]          i_radius,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [mer_pkg::X_W-1:0]     o_x_pos,
    output logic signed [mer_pkg::Y_W-1:0]     o_y_pos,
    output logic                               o_last
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SQ   = 11'b000_0000_0010,
        S_CUBE = 11'b000_0000_0100,
        S_INIT = 11'b000_0000_1000,
        S_P1   = 11'b000_0001_0000,
        S_P2   = 11'b000_0010_0000,
        S_P3   = 11'b000_0100_0000,
        S_P4   = 11'b000_1000_0000,
        S_P5   = 11'b001_0000_0000,
        S_UPD  = 11'b010_0000_0000,
        S_EMIT = 11'b100_0000_0000
    } t_state;

    t_state                                 r_state, n_state;
    logic [mer_pkg::RAD_W-1:0]              r_rad, n_rad;
    logic [mer_pkg::RSQ_W-1:0]              r_ry2, n_ry2;
    logic signed [mer_pkg::X_W-1:0]         r_x, n_x;
    logic signed [mer_pkg::Y_W-1:0]         r_y, n_y;
    logic signed [mer_pkg::DEC_W-1:0]       r_dec, n_dec;
    logic signed [mer_pkg::DSTEP_W-1:0]     r_dx, n_dx;
    logic signed [mer_pkg::DSTEP_W-1:0]     r_dy, n_dy;
    logic signed [mer_pkg::MUL_A_W-1:0]     r_t, n_t;
    logic                                   r_reg2, n_reg2;
    logic                                   r_active, n_active;

    logic signed [mer_pkg::MUL_A_W-1:0]     mul_a;
    logic signed [mer_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [mer_pkg::PROD_W-1:0]      prod;

    mer_pkg::t_emit_req                     emit_req;
    logic                                   emit_busy;

    logic                                   accept;
    logic signed [mer_pkg::DEC_W-1:0]       ry2_w;
    logic signed [mer_pkg::DSTEP_W-1:0]     dx_inc, dy_dec;
    logic signed [mer_pkg::DEC_W-1:0]       dx_inc_w, dy_dec_w;
    logic signed [mer_pkg::X_W+1:0]         two_x1;
    logic signed [mer_pkg::Y_W:0]           ym1;
    logic signed [mer_pkg::MUL_A_W-1:0]     sq_diff;
    logic signed [mer_pkg::DEC_W-1:0]       n4_adj;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);

    assign ry2_w    = {{(mer_pkg::DEC_W-mer_pkg::RSQ_W){1'b0}}, r_ry2};
    assign dx_inc   = r_dx + mer_pkg::DSTEP_W'({r_ry2, 1'b0});
    assign dy_dec   = r_dy - mer_pkg::DSTEP_W'({r_ry2, 3'b000});
    assign dx_inc_w = {{(mer_pkg::DEC_W-mer_pkg::DSTEP_W){dx_inc[mer_pkg::DSTEP_W-1]}}, dx_inc};
    assign dy_dec_w = {{(mer_pkg::DEC_W-mer_pkg::DSTEP_W){dy_dec[mer_pkg::DSTEP_W-1]}}, dy_dec};
    assign two_x1   = {r_x[mer_pkg::X_W-1], r_x, 1'b1};
    assign ym1      = {r_y[mer_pkg::Y_W-1], r_y} - (mer_pkg::Y_W+1)'(1);
    assign sq_diff  = prod[mer_pkg::MUL_A_W-1:0]
                    - {{(mer_pkg::MUL_A_W-mer_pkg::RSQ_W){1'b0}}, r_ry2};
    // quarter units back to whole units, rounding toward zero
    assign n4_adj   = prod + (prod[mer_pkg::PROD_W-1] ? mer_pkg::DEC_W'(3) : '0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = mer_pkg::MUL_A_W'(r_rad);
                mul_b = mer_pkg::MUL_B_W'(r_rad);
            end
            S_CUBE: begin
                mul_a = mer_pkg::MUL_A_W'(prod[mer_pkg::RSQ_W-1:0]);
                mul_b = mer_pkg::MUL_B_W'(r_rad);
            end
            S_P1: begin
                mul_a = mer_pkg::MUL_A_W'(two_x1);
                mul_b = mer_pkg::MUL_B_W'(two_x1);
            end
            S_P2: begin
                mul_a = mer_pkg::MUL_A_W'(ym1);
                mul_b = mer_pkg::MUL_B_W'(ym1);
            end
            S_P4: begin
                mul_a = r_t;
                mul_b = mer_pkg::MUL_B_W'(r_ry2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mer_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        n_state  = r_state;
        n_rad    = r_rad;
        n_ry2    = r_ry2;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_t      = r_t;
        n_reg2   = r_reg2;
        n_active = r_active;

        emit_req       = '0;
        emit_req.x     = r_x;
        emit_req.y     = r_y;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_mode) begin
                        n_rad   = (i_radius > mer_pkg::RAD_MAX) ? mer_pkg::RAD_MAX : i_radius;
                        n_state = S_SQ;
                    end else if (r_active) begin
                        if (!r_reg2 && !(r_dx < r_dy)) begin
                            n_state = S_P1;
                        end else begin
                            n_state = S_UPD;
                        end
                    end
                end
            end
            S_SQ: begin
                n_state = S_CUBE;
            end
            S_CUBE: begin
                n_ry2   = prod[mer_pkg::RSQ_W-1:0];
                n_state = S_INIT;
            end
            S_INIT: begin
                n_x      = '0;
                n_y      = mer_pkg::Y_W'(r_rad);
                n_dec    = (ry2_w <<< 1) - (prod <<< 2);
                n_dx     = '0;
                n_dy     = {prod[mer_pkg::DSTEP_W-4:0], 3'b000};
                n_reg2   = 1'b0;
                n_active = 1'b1;
                n_state  = S_IDLE;
            end
            S_P1: begin
                n_state = S_P2;
            end
            S_P2: begin
                n_t     = prod[mer_pkg::MUL_A_W-1:0];
                n_state = S_P3;
            end
            S_P3: begin
                n_t     = r_t + (sq_diff <<< 4);
                n_state = S_P4;
            end
            S_P4: begin
                n_state = S_P5;
            end
            S_P5: begin
                n_dec   = n4_adj >>> 2;
                n_reg2  = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!r_reg2) begin
                    n_x  = r_x + mer_pkg::X_W'(1);
                    n_dx = dx_inc;
                    if (r_dec[mer_pkg::DEC_W-1]) begin
                        n_dec = r_dec + ry2_w + dx_inc_w;
                    end else begin
                        n_y   = r_y - mer_pkg::Y_W'(1);
                        n_dy  = dy_dec;
                        n_dec = r_dec + ry2_w + dx_inc_w - dy_dec_w;
                    end
                end else begin
                    n_y  = r_y - mer_pkg::Y_W'(1);
                    n_dy = dy_dec;
                    if (r_dec > 0) begin
                        n_dec = r_dec + (ry2_w <<< 2) - dy_dec_w;
                    end else begin
                        n_x   = r_x + mer_pkg::X_W'(1);
                        n_dx  = dx_inc;
                        n_dec = r_dec + (ry2_w <<< 2) - dy_dec_w + dx_inc_w;
                    end
                end
                emit_req.valid = 1'b1;
                emit_req.last  = r_reg2 && (r_y == '0);
                if (r_reg2 && (r_y == '0)) begin
                    n_active = 1'b0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!emit_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_reg2   <= 1'b0;
            r_rad    <= '0;
            r_ry2    <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_reg2   <= n_reg2;
            r_rad    <= n_rad;
            r_ry2    <= n_ry2;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
    end

    mer_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (emit_req),
        .o_busy  (emit_busy),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_x_pos (o_x_pos),
        .o_y_pos (o_y_pos),
        .o_last  (o_last)
    );

endmodule
